// File: rtl/core/rsi_pkg.sv
`default_nettype none

package rsi_pkg;

  // sign of a value, both clear means zero
  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

  // strictly opposite signs, a zero on either side never counts
  function automatic logic opposite(sgn_t a, sgn_t b);
    logic res;
    res = (a.pos && b.neg) || (a.neg && b.pos);
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rsi_query_if.sv
`default_nettype none

interface rsi_query_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  rect_left;
  logic signed [COORD_BITS-1:0]  rect_top;
  logic        [COORD_BITS-2:0]  rect_width;
  logic        [COORD_BITS-2:0]  rect_height;
  logic signed [COORD_BITS-1:0]  seg_start_x;
  logic signed [COORD_BITS-1:0]  seg_start_y;
  logic signed [COORD_BITS-1:0]  seg_end_x;
  logic signed [COORD_BITS-1:0]  seg_end_y;

  modport source (
    output valid, rect_left, rect_top, rect_width, rect_height,
           seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    input  ready
  );

  modport sink (
    input  valid, rect_left, rect_top, rect_width, rect_height,
           seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/rsi_result_if.sv
`default_nettype none

interface rsi_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/rsi_corner_sign.sv
`default_nettype none

// Orientation of each rectangle corner against the segment line:
//   o(k) = dx*(ky-cy) - dy*(kx-cx), split into shared products.
module rsi_corner_sign
  import rsi_pkg::*;
#(
  parameter int unsigned PROD_BITS = 35
) (
  input  logic signed [PROD_BITS-1:0] prod_top_i,
  input  logic signed [PROD_BITS-1:0] prod_bot_i,
  input  logic signed [PROD_BITS-1:0] prod_left_i,
  input  logic signed [PROD_BITS-1:0] prod_right_i,
  output sgn_t                        tl_o,
  output sgn_t                        tr_o,
  output sgn_t                        bl_o,
  output sgn_t                        br_o
);

  localparam int unsigned OB = PROD_BITS + 1;

  logic signed [OB-1:0] o_tl, o_tr, o_bl, o_br;

  assign o_tl = OB'(prod_top_i) - OB'(prod_left_i);
  assign o_tr = OB'(prod_top_i) - OB'(prod_right_i);
  assign o_bl = OB'(prod_bot_i) - OB'(prod_left_i);
  assign o_br = OB'(prod_bot_i) - OB'(prod_right_i);

  assign tl_o = '{pos: !o_tl[OB-1] && (o_tl != '0), neg: o_tl[OB-1]};
  assign tr_o = '{pos: !o_tr[OB-1] && (o_tr != '0), neg: o_tr[OB-1]};
  assign bl_o = '{pos: !o_bl[OB-1] && (o_bl != '0), neg: o_bl[OB-1]};
  assign br_o = '{pos: !o_br[OB-1] && (o_br != '0), neg: o_br[OB-1]};

endmodule

`default_nettype wire

// File: rtl/core/rect_segment_intersect.sv
`default_nettype none

// Throughput: one query per cycle; stages hold and bubbles collapse on a stall.
// Stages: corners and deltas, operands and edge-span tests, four multipliers,
// corner orientation signs, edge combine into the output register.
// Reset (rst_ni low, asynchronous) empties the pipeline; no other state.
module rect_segment_intersect
  import rsi_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  rsi_query_if.sink    in_i,
  rsi_result_if.source out_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned C1 = COORD_BITS + 1;
  localparam int unsigned C2 = COORD_BITS + 2;
  localparam int unsigned P  = 2 * COORD_BITS + 3;

  // per-stage valid and advance
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || out_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;
  assign out_o.valid = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: far corner, segment deltas
  logic signed [C-1:0]  l1_q, t1_q, cx1_q, cy1_q, dx1_q, dy1_q;
  logic signed [C1-1:0] r1_q, b1_q, dxs1_q, dys1_q;
  logic                 wpos1_q, hpos1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      l1_q    <= in_i.rect_left;
      t1_q    <= in_i.rect_top;
      cx1_q   <= in_i.seg_start_x;
      cy1_q   <= in_i.seg_start_y;
      dx1_q   <= in_i.seg_end_x;
      dy1_q   <= in_i.seg_end_y;
      r1_q    <= C1'(in_i.rect_left) + $signed({2'b00, in_i.rect_width});
      b1_q    <= C1'(in_i.rect_top) + $signed({2'b00, in_i.rect_height});
      dxs1_q  <= C1'(in_i.seg_end_x) - C1'(in_i.seg_start_x);
      dys1_q  <= C1'(in_i.seg_end_y) - C1'(in_i.seg_start_y);
      wpos1_q <= in_i.rect_width != '0;
      hpos1_q <= in_i.rect_height != '0;
    end
  end

  // stage 2: multiplier operands, endpoint sides of each edge line
  logic signed [C1-1:0] cy_x, dy_x, cx_x, dx_x, t_x, l_x;
  sgn_t                 s_ct, s_dt, s_cb, s_db, s_cl, s_dl, s_cr, s_dr;

  assign cy_x = C1'(cy1_q);
  assign dy_x = C1'(dy1_q);
  assign cx_x = C1'(cx1_q);
  assign dx_x = C1'(dx1_q);
  assign t_x  = C1'(t1_q);
  assign l_x  = C1'(l1_q);

  assign s_ct = '{pos: cy_x > t_x,  neg: cy_x < t_x};
  assign s_dt = '{pos: dy_x > t_x,  neg: dy_x < t_x};
  assign s_cb = '{pos: cy_x > b1_q, neg: cy_x < b1_q};
  assign s_db = '{pos: dy_x > b1_q, neg: dy_x < b1_q};
  assign s_cl = '{pos: cx_x > l_x,  neg: cx_x < l_x};
  assign s_dl = '{pos: dx_x > l_x,  neg: dx_x < l_x};
  assign s_cr = '{pos: cx_x > r1_q, neg: cx_x < r1_q};
  assign s_dr = '{pos: dx_x > r1_q, neg: dx_x < r1_q};

  logic signed [C1-1:0] dxs2_q, dys2_q;
  logic signed [C2-1:0] ty2_q, by2_q, lx2_q, rx2_q;
  logic                 top2_q, bot2_q, lft2_q, rgt2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      dxs2_q <= dxs1_q;
      dys2_q <= dys1_q;
      ty2_q  <= C2'(t1_q) - C2'(cy1_q);
      by2_q  <= C2'(b1_q) - C2'(cy1_q);
      lx2_q  <= C2'(l1_q) - C2'(cx1_q);
      rx2_q  <= C2'(r1_q) - C2'(cx1_q);
      // a degenerate edge gives zero orientations and never counts
      top2_q <= wpos1_q && opposite(s_ct, s_dt);
      bot2_q <= wpos1_q && opposite(s_cb, s_db);
      lft2_q <= hpos1_q && opposite(s_cl, s_dl);
      rgt2_q <= hpos1_q && opposite(s_cr, s_dr);
    end
  end

  // stage 3: shared products
  logic signed [P-1:0] pt3_q, pb3_q, pl3_q, pr3_q;
  logic                top3_q, bot3_q, lft3_q, rgt3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pt3_q  <= P'(dxs2_q) * P'(ty2_q);
      pb3_q  <= P'(dxs2_q) * P'(by2_q);
      pl3_q  <= P'(dys2_q) * P'(lx2_q);
      pr3_q  <= P'(dys2_q) * P'(rx2_q);
      top3_q <= top2_q;
      bot3_q <= bot2_q;
      lft3_q <= lft2_q;
      rgt3_q <= rgt2_q;
    end
  end

  // stage 4: corner orientation signs
  sgn_t tl_s, tr_s, bl_s, br_s;

  rsi_corner_sign #(
    .PROD_BITS (P)
  ) u_corner_sign (
    .prod_top_i   (pt3_q),
    .prod_bot_i   (pb3_q),
    .prod_left_i  (pl3_q),
    .prod_right_i (pr3_q),
    .tl_o         (tl_s),
    .tr_o         (tr_s),
    .bl_o         (bl_s),
    .br_o         (br_s)
  );

  sgn_t tl4_q, tr4_q, bl4_q, br4_q;
  logic top4_q, bot4_q, lft4_q, rgt4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      tl4_q  <= tl_s;
      tr4_q  <= tr_s;
      bl4_q  <= bl_s;
      br4_q  <= br_s;
      top4_q <= top3_q;
      bot4_q <= bot3_q;
      lft4_q <= lft3_q;
      rgt4_q <= rgt3_q;
    end
  end

  // stage 5: any edge that the segment straddles and whose corners lie strictly on both sides of the segment
  logic hit_d;

  assign hit_d = (top4_q && opposite(tr4_q, tl4_q))
              || (rgt4_q && opposite(br4_q, tr4_q))
              || (lft4_q && opposite(bl4_q, tl4_q))
              || (bot4_q && opposite(br4_q, bl4_q));

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_o.hit <= hit_d;
    end
  end

`ifndef SYNTHESIS
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while output drains");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v1_q)
    else $error("accepted word lost at first stage");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && en5 |=> out_o.valid)
    else $error("result lost at output register");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned NUM_RANDOM = 1500;
  localparam int unsigned MAX_IDLE   = 18;

  typedef struct {
    bit signed [COORD_BITS-1:0] rect_left;
    bit signed [COORD_BITS-1:0] rect_top;
    bit        [COORD_BITS-2:0] rect_width;
    bit        [COORD_BITS-2:0] rect_height;
    bit signed [COORD_BITS-1:0] seg_start_x;
    bit signed [COORD_BITS-1:0] seg_start_y;
    bit signed [COORD_BITS-1:0] seg_end_x;
    bit signed [COORD_BITS-1:0] seg_end_y;
  } query_t;

  class hit_scoreboard;
    bit predicted_hits[$];
    int errors = 0;

    // sign of the cross product (q-p) x (r-p); exact in 64 bits
    function int orient_sign(longint px, longint py, longint qx, longint qy,
                             longint rx, longint ry);
      longint v;
      v = (qx - px) * (ry - py) - (qy - py) * (rx - px);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
    endfunction

    function bit edge_crossed(longint ax, longint ay, longint bx, longint by,
                              longint cx, longint cy, longint dx, longint dy);
      int s1, s2, s3, s4;
      s1 = orient_sign(ax, ay, bx, by, cx, cy);
      s2 = orient_sign(ax, ay, bx, by, dx, dy);
      s3 = orient_sign(cx, cy, dx, dy, bx, by);
      s4 = orient_sign(cx, cy, dx, dy, ax, ay);
      return (s1 * s2 < 0) && (s3 * s4 < 0);
    endfunction

    function bit predict_hit(query_t q);
      longint l, t, r, b, cx, cy, dx, dy;
      l  = longint'(q.rect_left);
      t  = longint'(q.rect_top);
      r  = l + longint'(q.rect_width);
      b  = t + longint'(q.rect_height);
      cx = longint'(q.seg_start_x);
      cy = longint'(q.seg_start_y);
      dx = longint'(q.seg_end_x);
      dy = longint'(q.seg_end_y);
      return edge_crossed(l, t, r, t, cx, cy, dx, dy) ||
             edge_crossed(r, t, r, b, cx, cy, dx, dy) ||
             edge_crossed(l, t, l, b, cx, cy, dx, dy) ||
             edge_crossed(l, b, r, b, cx, cy, dx, dy);
    endfunction

    function void note_query(query_t q);
      predicted_hits = {predicted_hits, predict_hit(q)};
    endfunction

    function void check_hit(logic hit);
      bit exp_hit;
      if (predicted_hits.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got hit=%b", $time, hit);
        errors++;
        return;
      end
      exp_hit = predicted_hits.pop_front();
      if (hit !== exp_hit) begin
        $display("%0t: hit mismatch, expected %b, got %b", $time, exp_hit, hit);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;   // both sides run without idle cycles while set

  query_t directed[$];

  hit_scoreboard sb = new();

  rsi_query_if #(.COORD_BITS(COORD_BITS)) query_bus ();
  rsi_result_if result_bus ();

  rect_segment_intersect #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (query_bus.sink),
    .out_o (result_bus.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic query_t make_query(int l, int t, int w, int h,
                                        int sx, int sy, int ex, int ey);
    query_t q;
    q.rect_left   = l[COORD_BITS-1:0];
    q.rect_top    = t[COORD_BITS-1:0];
    q.rect_width  = w[COORD_BITS-2:0];
    q.rect_height = h[COORD_BITS-2:0];
    q.seg_start_x = sx[COORD_BITS-1:0];
    q.seg_start_y = sy[COORD_BITS-1:0];
    q.seg_end_x   = ex[COORD_BITS-1:0];
    q.seg_end_y   = ey[COORD_BITS-1:0];
    return q;
  endfunction

  function automatic void add_directed(query_t q);
    directed = {directed, q};
  endfunction

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // random point in a window reaching a bit beyond [base, base+span]
  function automatic int near_coord(int base, int span);
    int margin;
    margin = span / 2 + 4;
    return clamp_coord(base - margin + int'($urandom_range(0, span + 2 * margin)));
  endfunction

  // lands on an edge line often, to hit touching and collinear cases
  function automatic int snap_coord(int base, int span);
    case ($urandom_range(0, 2))
      0: return base;
      1: return clamp_coord(base + span);
      default: return near_coord(base, span);
    endcase
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic int extreme_size();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    int l, t, w, h, mode;
    mode = $urandom_range(0, 9);
    l = int'($urandom_range(0, 65535)) - 32768;
    t = int'($urandom_range(0, 65535)) - 32768;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 300);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 300);
    case (mode)
      0, 1: begin
        q.rect_left   = COORD_BITS'($urandom);
        q.rect_top    = COORD_BITS'($urandom);
        q.rect_width  = (COORD_BITS-1)'($urandom);
        q.rect_height = (COORD_BITS-1)'($urandom);
        q.seg_start_x = COORD_BITS'($urandom);
        q.seg_start_y = COORD_BITS'($urandom);
        q.seg_end_x   = COORD_BITS'($urandom);
        q.seg_end_y   = COORD_BITS'($urandom);
      end
      8: q = make_query(l, t, w, h, snap_coord(l, w), snap_coord(t, h),
                        snap_coord(l, w), snap_coord(t, h));
      9: q = make_query(extreme_coord(), extreme_coord(), extreme_size(), extreme_size(),
                        extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
      default: q = make_query(l, t, w, h, near_coord(l, w), near_coord(t, h),
                              near_coord(l, w), near_coord(t, h));
    endcase
    return q;
  endfunction

  task automatic send_query(query_t q);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      query_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    query_bus.valid       <= 1'b1;
    query_bus.rect_left   <= q.rect_left;
    query_bus.rect_top    <= q.rect_top;
    query_bus.rect_width  <= q.rect_width;
    query_bus.rect_height <= q.rect_height;
    query_bus.seg_start_x <= q.seg_start_x;
    query_bus.seg_start_y <= q.seg_start_y;
    query_bus.seg_end_x   <= q.seg_end_x;
    query_bus.seg_end_y   <= q.seg_end_y;
    do @(posedge clk_i); while (query_bus.ready !== 1'b1);
    sb.note_query(q);
  endtask

  task automatic take_results();
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (result_bus.valid !== 1'b1);
      sb.check_hit(result_bus.hit);
    end
  endtask

  initial begin
    rst_ni                <= 1'b0;
    query_bus.valid       <= 1'b0;
    query_bus.rect_left   <= '0;
    query_bus.rect_top    <= '0;
    query_bus.rect_width  <= '0;
    query_bus.rect_height <= '0;
    query_bus.seg_start_x <= '0;
    query_bus.seg_start_y <= '0;
    query_bus.seg_end_x   <= '0;
    query_bus.seg_end_y   <= '0;
    result_bus.ready      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    take_results();
  end

  initial begin
    int waited;
    steady = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // rectangle x 0..100, y 0..50
    add_directed(make_query(0, 0, 100, 50, -10, 25, 110, 25));   // through both sides
    add_directed(make_query(0, 0, 100, 50, 50, -10, 50, 60));    // through top and bottom
    add_directed(make_query(0, 0, 100, 50, 10, 10, 90, 40));     // wholly inside
    add_directed(make_query(0, 0, 100, 50, 50, 0, 50, -20));     // endpoint on top edge
    add_directed(make_query(0, 0, 100, 50, -10, 0, 110, 0));     // along top edge
    add_directed(make_query(0, 0, 100, 50, -10, -10, 10, 10));   // through a corner
    add_directed(make_query(0, 0, 100, 50, 90, 25, 120, 25));    // out through right
    add_directed(make_query(0, 0, 100, 50, -20, 25, 20, 25));    // in through left
    add_directed(make_query(0, 0, 100, 50, 50, 40, 50, 80));     // out through bottom
    add_directed(make_query(0, 0, 100, 50, 200, 200, 300, 300)); // far miss
    add_directed(make_query(0, 0, 100, 50, 0, 10, 0, 80));       // overlaps left edge
    add_directed(make_query(0, 0, 100, 50, -10, 60, 110, 60));   // passes below
    add_directed(make_query(0, 0, 100, 50, 10, 10, 10, 10));     // point segment
    add_directed(make_query(5, 5, 0, 20, 0, 10, 10, 10));        // zero width
    add_directed(make_query(5, 5, 30, 0, 10, 0, 10, 10));        // zero height
    add_directed(make_query(5, 5, 0, 0, 0, 0, 10, 10));          // point rectangle
    add_directed(make_query(-32768, -32768, 32767, 32767,
                            -32768, 32767, 32767, -32768));
    add_directed(make_query(32767, 32767, 32767, 32767,
                            -32768, -32768, 32767, 32767));
    add_directed(make_query(-32768, 32767, 32767, 0, 0, -32768, 0, 32767));
    add_directed(make_query(-1, -1, 32767, 32767, -32768, 0, 32767, 1));
    add_directed(make_query(-32768, -32768, 0, 32767,
                            -32768, -32768, -32768, 32767));
    add_directed(make_query(-1, -1, 1, 1, -32768, 32767, 32767, -32768));
    foreach (directed[i]) send_query(directed[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 150 == 0) steady = ($urandom_range(0, 2) == 0);
      send_query(random_query());
    end
    steady = 1'b0;
    query_bus.valid <= 1'b0;

    waited = 0;
    while (sb.predicted_hits.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.predicted_hits.size() != 0)
      $display("%0t: %0d result words never arrived", $time, sb.predicted_hits.size());
    if (sb.errors == 0 && sb.predicted_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/rsi_pkg.sv
rtl/core/rsi_query_if.sv
rtl/core/rsi_result_if.sv
rtl/core/rsi_corner_sign.sv
rtl/core/rect_segment_intersect.sv
verif/tb_top.sv
